[hdl/oaie_pkg.sv]
// Shared types and constants for the ordered array insert/erase block.
`timescale 1ns / 1ps
`default_nettype none

package oaie_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = 7;
    localparam int DATA_W = 32;
    localparam int CAP_W  = 7;

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_READ   = 2'd1,
        REQ_INSERT = 2'd2,
        REQ_ERASE  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INS_PUT,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the incoming word
        logic decide;      // latch the verdict and start the shift pointer
        logic wr_tail;     // write the value behind the last entry
        logic rd_nb;       // read the neighbor of the shift pointer
        logic shift_step;  // move the read entry to the pointer, step the pointer
        logic put_val;     // write the value at the request index
        logic finish;      // load the result register and update the count
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_req req;
        logic ok;          // request passes its bound checks
        logic shift_empty; // no entries need to move
        logic shift_done;  // the current step moves the last entry
        logic out_free;    // the result register can take a new word
    } t_status;

endpackage

`default_nettype wire

[hdl/ordered_array_insert_erase.sv]
// Top level of the ordered array block: stream ports, register port, controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Keeps an ordered array of up to 64 signed 32-bit words and answers append, read,
// insert and erase requests, one result word per request word. Requests are handled
// one at a time. Append, read and any rejected request go from the idle state through
// the decide state to the finish state. An insert or erase moves entries one place per
// shift step through the storage RAM, whose read data is registered (a read state, then
// a write state); an insert then writes its value at the request index.
// A new request word is taken once the previous result is registered; the result
// register holds it until the downstream side takes it. Capacity (register 0) may
// only be written while no request is in flight; values above 64 act as 64.

module ordered_array_insert_erase (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // index[6:0], value[38:7], zero[39]
    input  wire logic [1:0]  s_axis_tuser,  // req_type[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [39:0] m_axis_tdata,  // read_data[31:0], fill_count[38:32], zero[39]
    output logic      [0:0]  m_axis_tuser,  // ok[0]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    import oaie_pkg::*;

    localparam logic ADDR_CAP = 1'b0;

    t_cmd              cmd;
    t_status           status;
    logic              in_valid;
    logic              cfg_we;
    logic [CAP_W-1:0]  cap;
    logic              out_ok;
    logic [DATA_W-1:0] out_data;
    logic [CNT_W-1:0]  out_cnt;

    assign pready   = 1'b1;
    assign cfg_we   = psel && penable && pwrite && (paddr[2] == ADDR_CAP);
    assign prdata   = (paddr[2] == ADDR_CAP) ? {{(32 - CAP_W){1'b0}}, cap} : '0;
    assign in_valid = s_axis_tvalid;

    oaie_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    oaie_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_req_type  (s_axis_tuser),
        .i_index     (s_axis_tdata[IDX_W-1:0]),
        .i_value     (s_axis_tdata[IDX_W+DATA_W-1:IDX_W]),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (pwdata[CAP_W-1:0]),
        .o_cap       (cap),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_ok    (out_ok),
        .o_out_data  (out_data),
        .o_out_cnt   (out_cnt)
    );

    assign m_axis_tdata = {1'b0, out_cnt, out_data};
    assign m_axis_tuser = out_ok;

endmodule

`default_nettype wire

[hdl/oaie_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module oaie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[hdl/oaie_ctrl.sv]
// Controller state machine that sequences each request through the datapath.
`timescale 1ns / 1ps
`default_nettype none

module oaie_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire oaie_pkg::t_status i_status,
    output oaie_pkg::t_cmd         o_cmd
);

    import oaie_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                case (i_status.req)
                    REQ_APPEND: begin
                        o_cmd.wr_tail = i_status.ok;
                        n_state       = S_FINISH;
                    end
                    REQ_INSERT: begin
                        if (!i_status.ok) begin
                            n_state = S_FINISH;
                        end else if (i_status.shift_empty) begin
                            n_state = S_INS_PUT;
                        end else begin
                            n_state = S_SHIFT_RD;
                        end
                    end
                    REQ_ERASE: begin
                        if (!i_status.ok || i_status.shift_empty) begin
                            n_state = S_FINISH;
                        end else begin
                            n_state = S_SHIFT_RD;
                        end
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_SHIFT_RD: begin
                o_cmd.rd_nb = 1'b1;
                n_state     = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                o_cmd.shift_step = 1'b1;
                if (!i_status.shift_done) begin
                    n_state = S_SHIFT_RD;
                end else if (i_status.req == REQ_INSERT) begin
                    n_state = S_INS_PUT;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_INS_PUT: begin
                o_cmd.put_val = 1'b1;
                n_state       = S_FINISH;
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/oaie_dp.sv]
// Datapath: request registers, count, capacity, shift pointer, storage and result register.
`timescale 1ns / 1ps
`default_nettype none

module oaie_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire oaie_pkg::t_cmd                i_cmd,
    output oaie_pkg::t_status                  o_status,
    input  wire logic [1:0]                    i_req_type,
    input  wire logic [oaie_pkg::IDX_W-1:0]    i_index,
    input  wire logic [oaie_pkg::DATA_W-1:0]   i_value,
    input  wire logic                          i_cfg_we,
    input  wire logic [oaie_pkg::CAP_W-1:0]    i_cfg_wdata,
    output logic      [oaie_pkg::CAP_W-1:0]    o_cap,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_out_ok,
    output logic      [oaie_pkg::DATA_W-1:0]   o_out_data,
    output logic      [oaie_pkg::CNT_W-1:0]    o_out_cnt
);

    import oaie_pkg::*;

    t_req               r_req;
    logic [IDX_W-1:0]   r_idx;
    logic [DATA_W-1:0]  r_val;
    logic [CNT_W-1:0]   r_cnt;
    logic [CAP_W-1:0]   r_cap;
    logic [ADDR_W-1:0]  r_ptr;
    logic               r_ok;
    logic               r_out_valid;
    logic               r_out_ok;
    logic [DATA_W-1:0]  r_out_data;
    logic [CNT_W-1:0]   r_out_cnt;

    logic [CAP_W-1:0]   cap_eff;
    logic               has_room;
    logic               idx_below;
    logic               ok_now;
    logic [ADDR_W-1:0]  nb;
    logic [CNT_W-1:0]   n_cnt;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [DATA_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [DATA_W-1:0]  mem_rdata;

    // Capacity above the built depth saturates to the depth.
    assign cap_eff   = (r_cap > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : r_cap;
    assign has_room  = CAP_W'(r_cnt) < cap_eff;
    assign idx_below = IDX_W'(r_cnt) > r_idx;

    always_comb begin
        case (r_req)
            REQ_APPEND: ok_now = has_room;
            REQ_READ:   ok_now = idx_below;
            REQ_INSERT: ok_now = has_room && (r_idx <= IDX_W'(r_cnt));
            REQ_ERASE:  ok_now = idx_below;
            default:    ok_now = 1'b0;
        endcase
    end

    // Insert walks down from the count toward the index, erase walks up.
    assign nb = (r_req == REQ_INSERT) ? (r_ptr - ADDR_W'(1)) : (r_ptr + ADDR_W'(1));

    assign o_status.req         = r_req;
    assign o_status.ok          = (r_req == REQ_READ) ? idx_below : ok_now;
    assign o_status.shift_empty = (r_req == REQ_INSERT)
                                ? (IDX_W'(r_cnt) == r_idx)
                                : ((r_idx + IDX_W'(1)) == IDX_W'(r_cnt));
    assign o_status.shift_done  = (r_req == REQ_INSERT)
                                ? (nb == r_idx[ADDR_W-1:0])
                                : ((CNT_W'(nb) + CNT_W'(1)) == r_cnt);
    assign o_status.out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_ptr;
        mem_wdata = mem_rdata;
        if (i_cmd.wr_tail) begin
            mem_we    = 1'b1;
            mem_waddr = r_cnt[ADDR_W-1:0];
            mem_wdata = r_val;
        end else if (i_cmd.put_val) begin
            mem_we    = 1'b1;
            mem_waddr = r_idx[ADDR_W-1:0];
            mem_wdata = r_val;
        end else if (i_cmd.shift_step) begin
            mem_we    = 1'b1;
        end
    end

    assign mem_raddr = i_cmd.rd_nb ? nb : r_idx[ADDR_W-1:0];

    oaie_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_cnt = r_cnt;
        if (r_ok) begin
            case (r_req)
                REQ_APPEND: n_cnt = r_cnt + CNT_W'(1);
                REQ_INSERT: n_cnt = r_cnt + CNT_W'(1);
                REQ_ERASE:  n_cnt = r_cnt - CNT_W'(1);
                default:    n_cnt = r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= t_req'(i_req_type);
            r_idx <= i_index;
            r_val <= i_value;
        end
        if (i_cmd.decide) begin
            r_ok  <= o_status.ok;
            r_ptr <= (r_req == REQ_INSERT) ? r_cnt[ADDR_W-1:0] : r_idx[ADDR_W-1:0];
        end else if (i_cmd.shift_step) begin
            r_ptr <= nb;
        end
        if (i_cmd.finish) begin
            r_out_ok   <= r_ok;
            r_out_data <= (r_ok && r_req == REQ_READ) ? mem_rdata : '0;
            r_out_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_cap       <= CAP_W'(DEPTH);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_cnt <= n_cnt;
            end
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_cap       = r_cap;
    assign o_out_valid = r_out_valid;
    assign o_out_ok    = r_out_ok;
    assign o_out_data  = r_out_data;
    assign o_out_cnt   = r_out_cnt;

endmodule

`default_nettype wire

[sim/ordered_array_insert_erase_test.sv]
// Self-checking testbench for the ordered array block: directed table, random requests, scoreboard.
`timescale 1ns / 1ps

module ordered_array_insert_erase_test;
    import oaie_pkg::*;

    localparam int          SEG_ITEMS   = 160;
    localparam int          TAIL_CYCLES = 2 * DEPTH + 16;
    localparam longint      CYCLE_LIMIT = 3_000_000;
    localparam logic [2:0]  CAP_ADDR    = 3'd0;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] read_data;
        logic [CAP_W-1:0]         fill_count;
    } t_outcome;

    typedef struct {
        bit                       is_cfg;
        t_req                     req;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] val;
        bit                       typed;
        t_outcome                 want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;  // index[6:0], value[38:7], zero[39]
    logic [1:0]  s_axis_tuser = '0;  // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;       // read_data[31:0], fill_count[38:32], zero[39]
    logic [0:0]  m_axis_tuser;       // ok[0]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copy of the array, its fill count and the capacity register.
    logic signed [DATA_W-1:0] shadow_words [DEPTH];
    int unsigned              shadow_count = 0;
    int unsigned              shadow_cap = 64;

    t_outcome    pending_results [$];
    t_row        plan [$];
    int unsigned mismatch_count = 0;
    longint      cycle_count = 0;
    int unsigned tx_idle_pct = 17;
    int unsigned rx_idle_pct = 61;
    int unsigned seg_cap [9]  = '{64, 1, 127, 17, 64, 0, 40, 2, 64};
    int unsigned seg_grow [9] = '{85, 50, 70, 60, 40, 50, 75, 50, 30};

    ordered_array_insert_erase dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // Applies one request to the shadow array and returns the result it must produce.
    function automatic t_outcome apply_request(input t_req req, input logic [IDX_W-1:0] idx,
                                               input logic signed [DATA_W-1:0] val);
        t_outcome    res;
        int unsigned room;
        res = '0;
        room = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
        case (req)
            REQ_APPEND: begin
                if (shadow_count < room) begin
                    shadow_words[shadow_count] = val;
                    shadow_count++;
                    res.ok = 1'b1;
                end
            end
            REQ_READ: begin
                if (idx < shadow_count) begin
                    res.read_data = shadow_words[idx];
                    res.ok = 1'b1;
                end
            end
            REQ_INSERT: begin
                if (idx <= shadow_count && shadow_count < room) begin
                    for (int j = shadow_count; j > idx; j--)
                        shadow_words[j] = shadow_words[j - 1];
                    shadow_words[idx] = val;
                    shadow_count++;
                    res.ok = 1'b1;
                end
            end
            default: begin
                if (idx < shadow_count) begin
                    for (int j = idx; j + 1 < shadow_count; j++)
                        shadow_words[j] = shadow_words[j + 1];
                    shadow_count--;
                    res.ok = 1'b1;
                end
            end
        endcase
        res.fill_count = shadow_count[CAP_W-1:0];
        return res;
    endfunction

    function automatic t_row make_row(input bit cfg, input t_req req, input logic [6:0] idx,
                                      input logic [31:0] val, input bit typed, input logic ok,
                                      input logic [31:0] data, input logic [6:0] cnt);
        t_row r;
        r.is_cfg = cfg;
        r.req = req;
        r.idx = idx;
        r.val = val;
        r.typed = typed;
        r.want.ok = ok;
        r.want.read_data = data;
        r.want.fill_count = cnt;
        return r;
    endfunction

    // Presents one request word and waits for it to be taken.
    task automatic send_request(input t_req req, input logic [IDX_W-1:0] idx,
                                input logic signed [DATA_W-1:0] val, input bit typed,
                                input t_outcome want);
        t_outcome got;
        int       gap;
        gap = 0;
        while (gap < 24 && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= {1'b0, val, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        got = apply_request(req, idx, val);
        pending_results.push_back(typed ? want : got);
    endtask

    // Stops the request stream and lets every outstanding result come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes the capacity register, then reads it back in the same bus tenure.
    task automatic write_capacity(input int unsigned cap);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CAP_ADDR;
        pwdata <= 32'(cap);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        shadow_cap = cap & 7'h7F;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== 32'(shadow_cap)) begin
            mismatch_count++;
            $error("capacity_limit: expected %0d, actual %0d", shadow_cap, prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge i_clk) begin : result_check
        t_outcome seen;
        t_outcome want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.ok = m_axis_tuser[0];
            seen.read_data = m_axis_tdata[31:0];
            seen.fill_count = m_axis_tdata[38:32];
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $error("unexpected result word: ok %0b read_data %0d fill_count %0d",
                       seen.ok, seen.read_data, seen.fill_count);
            end else begin
                want = pending_results.pop_front();
                if (seen.ok !== want.ok) begin
                    mismatch_count++;
                    $error("ok: expected %0b, actual %0b", want.ok, seen.ok);
                end
                if (seen.read_data !== want.read_data) begin
                    mismatch_count++;
                    $error("read_data: expected %0d, actual %0d", want.read_data,
                           seen.read_data);
                end
                if (seen.fill_count !== want.fill_count) begin
                    mismatch_count++;
                    $error("fill_count: expected %0d, actual %0d", want.fill_count,
                           seen.fill_count);
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_req                     req;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] val;
        int unsigned              pick;
        t_row                     r;

        // Empty array, bounds at both ends, the capacity at zero, lowered below the
        // count and above the built depth.
        plan.push_back(make_row(0, REQ_READ,   0,   0,            1, 0, 0,            0));
        plan.push_back(make_row(0, REQ_ERASE,  0,   0,            1, 0, 0,            0));
        plan.push_back(make_row(0, REQ_INSERT, 1,   32'h1,        1, 0, 0,            0));
        plan.push_back(make_row(0, REQ_INSERT, 0,   32'h80000000, 1, 1, 0,            1));
        plan.push_back(make_row(0, REQ_APPEND, 0,   32'h7FFFFFFF, 1, 1, 0,            2));
        plan.push_back(make_row(0, REQ_READ,   0,   0,            1, 1, 32'h80000000, 2));
        plan.push_back(make_row(0, REQ_READ,   1,   0,            1, 1, 32'h7FFFFFFF, 2));
        plan.push_back(make_row(0, REQ_INSERT, 1,   32'hFFFFFFFF, 0, 0, 0,            0));
        plan.push_back(make_row(0, REQ_APPEND, 127, 32'h0,        0, 0, 0,            0));
        plan.push_back(make_row(0, REQ_READ,   127, 0,            1, 0, 0,            4));
        plan.push_back(make_row(0, REQ_ERASE,  127, 0,            1, 0, 0,            4));
        plan.push_back(make_row(0, REQ_INSERT, 5,   32'h2,        1, 0, 0,            4));
        plan.push_back(make_row(0, REQ_INSERT, 4,   32'h55555555, 0, 0, 0,            0));
        plan.push_back(make_row(0, REQ_ERASE,  0,   0,            0, 0, 0,            0));
        plan.push_back(make_row(0, REQ_READ,   3,   0,            0, 0, 0,            0));
        plan.push_back(make_row(1, REQ_APPEND, 0,   0,            0, 0, 0,            0));
        plan.push_back(make_row(0, REQ_APPEND, 0,   32'hAAAAAAAA, 1, 0, 0,            4));
        plan.push_back(make_row(0, REQ_INSERT, 0,   32'hAAAAAAAA, 1, 0, 0,            4));
        plan.push_back(make_row(0, REQ_READ,   0,   0,            0, 0, 0,            0));
        plan.push_back(make_row(1, REQ_APPEND, 0,   3,            0, 0, 0,            0));
        plan.push_back(make_row(0, REQ_APPEND, 0,   32'h3,        1, 0, 0,            4));
        plan.push_back(make_row(0, REQ_ERASE,  3,   0,            0, 0, 0,            0));
        plan.push_back(make_row(0, REQ_INSERT, 3,   32'hAAAAAAAA, 1, 0, 0,            3));
        plan.push_back(make_row(0, REQ_ERASE,  0,   0,            0, 0, 0,            0));
        plan.push_back(make_row(0, REQ_INSERT, 0,   32'hAAAAAAAA, 0, 0, 0,            0));
        plan.push_back(make_row(1, REQ_APPEND, 0,   127,          0, 0, 0,            0));
        plan.push_back(make_row(0, REQ_APPEND, 0,   32'h12345678, 0, 0, 0,            0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            r = plan[k];
            if (r.is_cfg) begin
                drain_results();
                write_capacity(r.val);
            end else begin
                send_request(r.req, r.idx, r.val, r.typed, r.want);
            end
        end

        for (int s = 0; s < 9; s++) begin
            drain_results();
            if (s == 3) begin
                tx_idle_pct = 61;
                rx_idle_pct = 17;
            end else if (s == 6) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_capacity(seg_cap[s]);
            repeat (SEG_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 25)
                    req = REQ_READ;
                else if ($urandom_range(99) < seg_grow[s])
                    req = $urandom_range(1) ? REQ_INSERT : REQ_APPEND;
                else
                    req = REQ_ERASE;

                // Mostly legal positions, with some past the end and a few far out.
                pick = $urandom_range(99);
                if (pick < 80) begin
                    if (req != REQ_INSERT && shadow_count > 0)
                        idx = IDX_W'($urandom_range(shadow_count - 1));
                    else
                        idx = IDX_W'($urandom_range(shadow_count));
                end else if (pick < 90) begin
                    idx = IDX_W'($urandom_range(127));
                end else if (pick < 95) begin
                    idx = IDX_W'(DEPTH);
                end else begin
                    idx = IDX_W'(shadow_count);
                end

                case ($urandom_range(9))
                    0:       val = 32'h80000000;
                    1:       val = 32'h7FFFFFFF;
                    2:       val = 32'hFFFFFFFF;
                    3:       val = 32'h0;
                    default: val = $urandom;
                endcase
                send_request(req, idx, val, 1'b0, '0);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
